FILE: rtl/ordered_list_insert_delete_engine_assert.svh
// Assertion macros shared by the list engine checker.
`ifndef ORDERED_LIST_INSERT_DELETE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, disabled during reset.
`define OLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

FILE: rtl/oli_pkg.sv
// Shared types and constants of the ordered list engine.
package oli_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int GROUP_SIZE      = 16;
    localparam int IDX_W           = 8;
    localparam int DATA_W          = 32;

    localparam logic [3:0] CMD_CLEAR      = 4'd0;
    localparam logic [3:0] CMD_INS_FIRST  = 4'd1;
    localparam logic [3:0] CMD_INS_AT     = 4'd2;
    localparam logic [3:0] CMD_INS_LAST   = 4'd3;
    localparam logic [3:0] CMD_DEL_FIRST  = 4'd4;
    localparam logic [3:0] CMD_DEL_AT     = 4'd5;
    localparam logic [3:0] CMD_DEL_LAST   = 4'd6;
    localparam logic [3:0] CMD_GET        = 4'd7;
    localparam logic [3:0] CMD_SET        = 4'd8;
    localparam logic [3:0] CMD_SEARCH     = 4'd9;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_BADIDX  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_INS  = 3'd1,
        OP_DEL  = 3'd2,
        OP_SET  = 3'd3,
        OP_GET  = 3'd4,
        OP_FIND = 3'd5
    } op_t;

    typedef struct packed {
        logic               en;
        op_t                op;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   count;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [3:0]         command;
        logic [IDX_W-1:0]   index;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [DATA_W-1:0] read_value;
        logic               found;
        logic [IDX_W-1:0]   length;
        logic               is_empty;
    } rsp_t;

endpackage

FILE: rtl/ordered_list_insert_delete_engine.sv
// Top level of the ordered list engine: command decode, cell row and result tree.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  cmd     | in        | cmd_valid / cmd_stall | command, index, value
//  rsp     | out       | rsp_valid / rsp_stall | status, read_value, found, length,
//          |           |                      | is_empty
//
// A request runs in three steps: decode against the length, an exec step in
// which every cell shifts, loads or compares at once while the group OR stage
// latches hits and read words, and a done step for the final OR into the response
// register. The next request is taken only once the engine is back in idle, so
// a new request waits while the current one is still in exec or done.
// Reset clears the length and the control state; entries need no clearing, since
// only slots below the length are ever read.
// A stalled response holds; the engine still takes a new request meanwhile and
// waits in its final step until the response register frees up.
module ordered_list_insert_delete_engine #(
    parameter int MAX_ENTRIES = oli_pkg::MAX_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  oli_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output oli_pkg::rsp_t  rsp
);

    localparam int NumGroups = (MAX_ENTRIES + oli_pkg::GROUP_SIZE - 1) / oli_pkg::GROUP_SIZE;
    localparam logic [oli_pkg::IDX_W-1:0] MaxCount = oli_pkg::IDX_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Control registers: count is live state, the rest describe the request in flight.
    logic [oli_pkg::IDX_W-1:0]  count_reg, count_next;
    oli_pkg::op_t               op_reg, op_next;
    logic [oli_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic [oli_pkg::DATA_W-1:0] value_reg;
    logic [1:0]                 status_reg, status_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    oli_pkg::rsp_t              rsp_reg;

    logic accept;
    logic rsp_free;

    oli_pkg::cell_ctrl_t ctrl;

    logic [oli_pkg::DATA_W-1:0] cell_entry [MAX_ENTRIES];
    logic                       cell_hit   [MAX_ENTRIES];
    logic [oli_pkg::DATA_W-1:0] cell_rd    [MAX_ENTRIES];

    logic                       grp_hit_reg  [NumGroups];
    logic                       grp_hit_next [NumGroups];
    logic [oli_pkg::DATA_W-1:0] grp_rd_reg   [NumGroups];
    logic [oli_pkg::DATA_W-1:0] grp_rd_next  [NumGroups];

    logic                       fin_hit;
    logic [oli_pkg::DATA_W-1:0] fin_rd;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Decode the request against the current length: status, cell op and new length.
    always_comb
    begin
        count_next  = count_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        if (accept)
        begin
            op_next     = oli_pkg::OP_NONE;
            pos_next    = cmd.index;
            status_next = oli_pkg::STATUS_OK;
            case (cmd.command)
                oli_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                oli_pkg::CMD_INS_FIRST, oli_pkg::CMD_INS_AT, oli_pkg::CMD_INS_LAST:
                begin
                    if (count_reg >= MaxCount)
                    begin
                        status_next = oli_pkg::STATUS_FULL;
                    end
                    else if ((cmd.command == oli_pkg::CMD_INS_AT) && (cmd.index > count_reg))
                    begin
                        status_next = oli_pkg::STATUS_BADIDX;
                    end
                    else
                    begin
                        op_next    = oli_pkg::OP_INS;
                        count_next = count_reg + 1'b1;
                        if (cmd.command == oli_pkg::CMD_INS_FIRST)
                        begin
                            pos_next = '0;
                        end
                        else if (cmd.command == oli_pkg::CMD_INS_LAST)
                        begin
                            pos_next = count_reg;
                        end
                    end
                end
                oli_pkg::CMD_DEL_FIRST, oli_pkg::CMD_DEL_AT, oli_pkg::CMD_DEL_LAST:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = oli_pkg::STATUS_EMPTY;
                    end
                    else if ((cmd.command == oli_pkg::CMD_DEL_AT) && (cmd.index >= count_reg))
                    begin
                        status_next = oli_pkg::STATUS_BADIDX;
                    end
                    else
                    begin
                        op_next    = oli_pkg::OP_DEL;
                        count_next = count_reg - 1'b1;
                        if (cmd.command == oli_pkg::CMD_DEL_FIRST)
                        begin
                            pos_next = '0;
                        end
                        else if (cmd.command == oli_pkg::CMD_DEL_LAST)
                        begin
                            pos_next = count_reg - 1'b1;
                        end
                    end
                end
                oli_pkg::CMD_GET:
                begin
                    if (cmd.index >= count_reg)
                    begin
                        status_next = oli_pkg::STATUS_BADIDX;
                    end
                    else
                    begin
                        op_next = oli_pkg::OP_GET;
                    end
                end
                oli_pkg::CMD_SET:
                begin
                    if (cmd.index >= count_reg)
                    begin
                        status_next = oli_pkg::STATUS_BADIDX;
                    end
                    else
                    begin
                        op_next = oli_pkg::OP_SET;
                    end
                end
                oli_pkg::CMD_SEARCH:
                begin
                    op_next = oli_pkg::OP_FIND;
                end
                default:
                begin
                    op_next = oli_pkg::OP_NONE;
                end
            endcase
        end
    end

    // Sequence: idle -> exec (cells act) -> done (response load, may wait).
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            op_reg        <= oli_pkg::OP_NONE;
            pos_reg       <= '0;
            status_reg    <= oli_pkg::STATUS_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request word for the cell row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= cmd.value;
        end
    end

    // The cell row acts only in the exec cycle; compares use the length as it stands then.
    assign ctrl.en    = (state_reg == ST_EXEC);
    assign ctrl.op    = op_reg;
    assign ctrl.pos   = pos_reg;
    assign ctrl.count = count_reg;
    assign ctrl.value = value_reg;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [oli_pkg::DATA_W-1:0] left_w;
        logic [oli_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_entry[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_w = cell_entry[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_entry[i+1];
        end

        oli_cell #(
            .POS (oli_pkg::IDX_W'(i))
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .entry (cell_entry[i]),
            .hit   (cell_hit[i]),
            .rd    (cell_rd[i])
        );
    end

    // First OR level: one group of cells each; at most one cell drives a nonzero read word.
    always_comb
    begin
        for (int g = 0; g < NumGroups; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_rd_next[g]  = '0;
            for (int k = 0; k < oli_pkg::GROUP_SIZE; k++)
            begin
                if (g * oli_pkg::GROUP_SIZE + k < MAX_ENTRIES)
                begin
                    grp_hit_next[g] = grp_hit_next[g] | cell_hit[g * oli_pkg::GROUP_SIZE + k];
                    grp_rd_next[g]  = grp_rd_next[g]  | cell_rd[g * oli_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            for (int g = 0; g < NumGroups; g++)
            begin
                grp_hit_reg[g] <= grp_hit_next[g];
                grp_rd_reg[g]  <= grp_rd_next[g];
            end
        end
    end

    // Second OR level over the groups.
    always_comb
    begin
        fin_hit = 1'b0;
        fin_rd  = '0;
        for (int g = 0; g < NumGroups; g++)
        begin
            fin_hit = fin_hit | grp_hit_reg[g];
            fin_rd  = fin_rd  | grp_rd_reg[g];
        end
    end

    // Load the response when the done step finds the output register free.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.read_value <= fin_rd;
            rsp_reg.found      <= fin_hit;
            rsp_reg.length     <= count_reg;
            rsp_reg.is_empty   <= (count_reg == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/oli_cell.sv
// One list slot: holds an entry and shifts, loads or compares it.
module oli_cell #(
    parameter logic [oli_pkg::IDX_W-1:0] POS = '0
) (
    input  logic                        clk,
    input  oli_pkg::cell_ctrl_t         ctrl,
    input  logic [oli_pkg::DATA_W-1:0]  left,
    input  logic [oli_pkg::DATA_W-1:0]  right,
    output logic [oli_pkg::DATA_W-1:0]  entry,
    output logic                        hit,
    output logic [oli_pkg::DATA_W-1:0]  rd
);

    logic [oli_pkg::DATA_W-1:0] entry_reg;
    logic [oli_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                oli_pkg::OP_INS:
                begin
                    if (POS > ctrl.pos)
                    begin
                        entry_next = left;
                    end
                    else if (POS == ctrl.pos)
                    begin
                        entry_next = ctrl.value;
                    end
                end
                oli_pkg::OP_DEL:
                begin
                    if (POS >= ctrl.pos)
                    begin
                        entry_next = right;
                    end
                end
                oli_pkg::OP_SET:
                begin
                    if (POS == ctrl.pos)
                    begin
                        entry_next = ctrl.value;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = (ctrl.op == oli_pkg::OP_FIND) && (POS < ctrl.count)
                   && (entry_reg == ctrl.value);
    assign rd    = ((ctrl.op == oli_pkg::OP_GET) && (POS == ctrl.pos)) ? entry_reg : '0;

endmodule

FILE: rtl/oli_checker.sv
// Port-level checks of the list engine, bound to the top level.
`include "ordered_list_insert_delete_engine_assert.svh"

module oli_checker #(
    parameter int MAX_ENTRIES = oli_pkg::MAX_ENTRIES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input oli_pkg::rsp_t rsp
);

    localparam logic [oli_pkg::IDX_W-1:0] MaxCount = oli_pkg::IDX_W'(MAX_ENTRIES);

    // A stalled response holds its payload.
    `OLI_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // The empty flag agrees with the reported length.
    `OLI_ASSERT_NOW(a_empty_len, clk, rst_n, rsp_valid, rsp.is_empty == (rsp.length == '0))

    // The length never passes the capacity.
    `OLI_ASSERT_NOW(a_len_max, clk, rst_n, rsp_valid, rsp.length <= MaxCount)

    // One request at a time: the engine is busy right after taking one.
    `OLI_ASSERT_NEXT(a_busy, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)

endmodule

bind ordered_list_insert_delete_engine oli_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_oli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
